/* src/pct_pkg.sv */
package pct_pkg;

    // Default table sizes
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_ENTITY_IDS = 4096;

    // Field widths on the stream ports
    localparam int CMD_W    = 3;
    localparam int ENT_W    = 12;
    localparam int SLOT_W   = 10;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 11;

    localparam int IN_BITS     = CMD_W + ENT_W + SLOT_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + SLOT_W + ENT_W + VAL_W + USED_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CREATE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_ENT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_SLOT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE_ENT = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd4;

endpackage

/* src/pct_ram.sv */
module pct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/packed_component_table.sv */
// packed_component_table: dense packed table of 64-bit per-entity values
// with an entity-to-slot map (sparse set, swap-remove on destroy).
//
// Channels: one request enters on s_axis_* and exactly one result leaves
// on m_axis_*, in request order. A request is taken when s_axis_tvalid
// and s_axis_tready are both high; a result when m_axis_tvalid and
// m_axis_tready are.
// Timing: one request at a time. Slot commands (destroy, read by slot,
// unknown codes) go from accept straight to the final step; entity
// commands (create, lookup, read/write by entity) first pass a map step
// for the dependent read of the map memory and then of the slot memories,
// and only then reach the final step.
// Presence is the usual sparse-set test: map[e] below the live count and
// slot_entity[map[e]] == e. Reset zeroes the live count and control, then
// the map memory is cleared entry by entry with s_axis_tready low, so every
// map entry holds a defined slot number.
// Output is a register: a new request is taken while a result waits.
// If the receiver stalls, the next request stops at its final step, the
// memories are not written, and it resumes once the output is taken.
module packed_component_table
    import pct_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ENTITY_IDS = DEF_ENTITY_IDS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // cmd[2:0], entity_id[14:3], slot_in[24:15], value_in[88:25], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[2:0], slot_out[12:3], entity_out[24:13], value_out[88:25],
    // used_count[99:89], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SW = $clog2(CAPACITY);
    localparam int EW = $clog2(ENTITY_IDS);
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAP   = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] clr_reg;

    // captured request
    logic [CMD_W-1:0]  cmd_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  val_reg;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // unpacked request fields
    logic [CMD_W-1:0]  in_cmd;
    logic [ENT_W-1:0]  in_ent;
    logic [SLOT_W-1:0] in_slot;
    logic [VAL_W-1:0]  in_val;

    // memory ports
    logic          se_wr_en, sv_wr_en, map_wr_en;
    logic [SW-1:0] slot_wr_addr, slot_rd_addr;
    logic [ENT_W-1:0] se_wr_data, se_rd_data;
    logic [VAL_W-1:0] sv_wr_data, sv_rd_data;
    logic [EW-1:0] map_wr_addr;
    logic [SW-1:0] map_wr_data, map_rd_data;
    logic          slot_rd_en;

    logic accept, out_free, fire, ent_cmd;
    logic ent_ok, present, slot_ok, full;

    // result fields
    logic [STATUS_W-1:0] res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [ENT_W-1:0]    res_ent;
    logic [VAL_W-1:0]    res_val;

    assign in_cmd  = s_axis_tdata[CMD_W-1:0];
    assign in_ent  = s_axis_tdata[CMD_W +: ENT_W];
    assign in_slot = s_axis_tdata[CMD_W + ENT_W +: SLOT_W];
    assign in_val  = s_axis_tdata[CMD_W + ENT_W + SLOT_W +: VAL_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign fire          = (state_reg == S_EXEC) && out_free;

    assign ent_cmd = (in_cmd == CMD_CREATE) || (in_cmd == CMD_LOOKUP) ||
                     (in_cmd == CMD_READ_ENT) || (in_cmd == CMD_WRITE_ENT);

    // Slot memories are read at accept for every command (destroy reads the
    // last live entry, the others the requested slot), and again in the map
    // step at the mapped slot for entity commands.
    always_comb
    begin
        slot_rd_en   = 1'b0;
        slot_rd_addr = map_rd_data;
        if (state_reg == S_MAP)
        begin
            slot_rd_en = 1'b1;
        end
        else if (accept)
        begin
            slot_rd_en = 1'b1;
            if (in_cmd == CMD_DESTROY)
            begin
                slot_rd_addr = SW'(count_reg - CW'(1));
            end
            else
            begin
                slot_rd_addr = SW'(in_slot);
            end
        end
    end

    pct_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_slot_entity (
        .clk     (clk),
        .wr_en   (se_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (se_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (se_rd_data)
    );

    pct_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_slot_value (
        .clk     (clk),
        .wr_en   (sv_wr_en),
        .wr_addr (slot_wr_addr),
        .wr_data (sv_wr_data),
        .rd_en   (slot_rd_en),
        .rd_addr (slot_rd_addr),
        .rd_data (sv_rd_data)
    );

    pct_ram #(.WIDTH(SW), .DEPTH(ENTITY_IDS)) u_entity_slot (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (accept),
        .rd_addr (EW'(in_ent)),
        .rd_data (map_rd_data)
    );

    // membership and range checks on the captured request
    assign ent_ok  = 32'(ent_reg) < 32'(ENTITY_IDS);
    assign present = ent_ok && (32'(map_rd_data) < 32'(count_reg)) &&
                     (se_rd_data == ent_reg);
    assign slot_ok = 32'(slot_reg) < 32'(count_reg);
    assign full    = 32'(count_reg) >= 32'(CAPACITY);

    // final step: decide, write back, form the result
    always_comb
    begin
        res_status   = ST_OK;
        res_slot     = '0;
        res_ent      = '0;
        res_val      = '0;
        count_next   = count_reg;
        se_wr_en     = 1'b0;
        sv_wr_en     = 1'b0;
        map_wr_en    = 1'b0;
        slot_wr_addr = map_rd_data;
        se_wr_data   = ent_reg;
        sv_wr_data   = val_reg;
        map_wr_addr  = EW'(ent_reg);
        map_wr_data  = SW'(count_reg);

        case (cmd_reg)
            CMD_CREATE:
            begin
                if (!ent_ok)
                begin
                    res_status = ST_ABSENT;
                end
                else if (present)
                begin
                    res_status = ST_PRESENT;
                end
                else if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_slot     = SLOT_W'(count_reg);
                    slot_wr_addr = SW'(count_reg);
                    se_wr_en     = fire;
                    sv_wr_en     = fire;
                    map_wr_en    = fire;
                    count_next   = count_reg + CW'(1);
                end
            end
            CMD_DESTROY:
            begin
                if (!slot_ok)
                begin
                    res_status = ST_BAD_SLOT;
                end
                else
                begin
                    // last entry moves into the freed slot
                    res_slot     = slot_reg;
                    slot_wr_addr = SW'(slot_reg);
                    se_wr_data   = se_rd_data;
                    sv_wr_data   = sv_rd_data;
                    map_wr_addr  = EW'(se_rd_data);
                    map_wr_data  = SW'(slot_reg);
                    se_wr_en     = fire;
                    sv_wr_en     = fire;
                    map_wr_en    = fire;
                    count_next   = count_reg - CW'(1);
                end
            end
            CMD_LOOKUP, CMD_READ_ENT, CMD_WRITE_ENT:
            begin
                if (!present)
                begin
                    res_status = ST_ABSENT;
                end
                else
                begin
                    res_slot = SLOT_W'(map_rd_data);
                    if (cmd_reg == CMD_READ_ENT)
                    begin
                        res_val = sv_rd_data;
                    end
                    if (cmd_reg == CMD_WRITE_ENT)
                    begin
                        sv_wr_en = fire;
                    end
                end
            end
            CMD_READ_SLOT:
            begin
                if (!slot_ok)
                begin
                    res_status = ST_BAD_SLOT;
                end
                else
                begin
                    res_slot = slot_reg;
                    res_ent  = se_rd_data;
                    res_val  = sv_rd_data;
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase

        // map clearing pass after reset
        if (state_reg == S_CLEAR)
        begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_reg;
            map_wr_data = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == EW'(ENTITY_IDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ent_cmd ? S_MAP : S_EXEC;
                end
            end
            S_MAP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + EW'(1);
            end
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            ent_reg  <= in_ent;
            slot_reg <= in_slot;
            val_reg  <= in_val;
        end
        if (fire)
        begin
            m_data_reg <= OUT_TDATA_W'({USED_W'(count_next), res_val, res_ent,
                                        res_slot, res_status});
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("live count above capacity");

    a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> (count_reg == $past(count_reg)))
        else $error("live count changed outside final step");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_EXEC))
        else $error("result appeared without a final step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request not in progress");
`endif

endmodule
